>>> design/toec_pkg.sv
// Shared constants, types and codes for the time-ordered event chain.
package toec_pkg;

    localparam int MAX_ENTRIES = 1024;
    localparam int TIME_BITS   = 48;
    localparam int ID_BITS     = 10;
    localparam int CNT_BITS    = $clog2(MAX_ENTRIES + 1);
    localparam int CMD_BITS    = 2;
    localparam int PDATA_BITS  = 64;
    localparam int PADDR_BITS  = 4;

    typedef logic [TIME_BITS-1:0] t_time;
    typedef logic [ID_BITS-1:0]   t_id;
    typedef logic [CNT_BITS-1:0]  t_cnt;
    typedef logic [CMD_BITS-1:0]  t_cmd;

    localparam t_cmd CMD_CLEAR   = 2'd0;
    localparam t_cmd CMD_LOAD    = 2'd1;
    localparam t_cmd CMD_RESCHED = 2'd2;

    // Register select bit of paddr: 8-byte register slots.
    localparam int   REG_SEL_BIT    = 3;
    localparam logic REG_TIME_LIMIT = 1'b0;

    typedef enum logic [1:0] {
        OP_HOLD,
        OP_INSERT,
        OP_POP
    } t_chain_op;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_REINS
    } t_state;

    // Broadcast to every cell of the chain.
    typedef struct packed {
        t_chain_op op;
        logic      after_eq;   // insert after equal times (load) or before (reschedule)
        t_time     key;
        t_id       id;
    } t_chain_ctl;

endpackage

>>> design/toec_cell.sv
// One slot of the sorted chain: holds a time and an id, shifts with its neighbors.
module toec_cell
    import toec_pkg::*;
(
    input  logic       i_clk,
    input  t_chain_ctl i_ctl,
    input  logic       i_occ,
    input  logic       i_left_gt,
    input  t_time      i_left_time,
    input  t_id        i_left_id,
    input  t_time      i_right_time,
    input  t_id        i_right_id,
    output t_time      o_time,
    output t_id        o_id,
    output logic       o_gt
);

    t_time r_time, n_time;
    t_id   r_id,   n_id;
    logic  w_gt;

    // Empty slots count as later than any key, so the insert point is the first one.
    always_comb begin
        if (!i_occ) begin
            w_gt = 1'b1;
        end else if (i_ctl.after_eq) begin
            w_gt = (r_time > i_ctl.key);
        end else begin
            w_gt = (r_time >= i_ctl.key);
        end
    end

    always_comb begin
        n_time = r_time;
        n_id   = r_id;
        case (i_ctl.op)
            OP_INSERT: begin
                if (i_left_gt) begin
                    n_time = i_left_time;
                    n_id   = i_left_id;
                end else if (w_gt) begin
                    n_time = i_ctl.key;
                    n_id   = i_ctl.id;
                end
            end
            OP_POP: begin
                n_time = i_right_time;
                n_id   = i_right_id;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_time <= n_time;
        r_id   <= n_id;
    end

    assign o_time = r_time;
    assign o_id   = r_id;
    assign o_gt   = w_gt;

endmodule

>>> design/toec_chain.sv
// Row of sorted cells with the head taps used by the controller.
module toec_chain
    import toec_pkg::*;
(
    input  logic       i_clk,
    input  t_chain_ctl i_ctl,
    input  t_cnt       i_count,
    output t_id        o_head_id,
    output t_id        o_head_next_id
);

    t_time w_time [MAX_ENTRIES];
    t_id   w_id   [MAX_ENTRIES];
    logic  w_gt   [MAX_ENTRIES];
    logic  w_occ  [MAX_ENTRIES];

    for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
        t_time w_lt, w_rt;
        t_id   w_li, w_ri;
        logic  w_lg;

        assign w_occ[i] = (i_count > CNT_BITS'(i));

        if (i == 0) begin : g_first
            assign w_lg = 1'b0;
            assign w_lt = i_ctl.key;
            assign w_li = i_ctl.id;
        end else begin : g_mid
            assign w_lg = w_gt[i-1];
            assign w_lt = w_time[i-1];
            assign w_li = w_id[i-1];
        end

        if (i == MAX_ENTRIES - 1) begin : g_last
            // Last slot empties on a pop; its content no longer counts.
            assign w_rt = w_time[i];
            assign w_ri = w_id[i];
        end else begin : g_inner
            assign w_rt = w_time[i+1];
            assign w_ri = w_id[i+1];
        end

        toec_cell u_cell (
            .i_clk        (i_clk),
            .i_ctl        (i_ctl),
            .i_occ        (w_occ[i]),
            .i_left_gt    (w_lg),
            .i_left_time  (w_lt),
            .i_left_id    (w_li),
            .i_right_time (w_rt),
            .i_right_id   (w_ri),
            .o_time       (w_time[i]),
            .o_id         (w_id[i]),
            .o_gt         (w_gt[i])
        );
    end

    assign o_head_id = w_id[0];

    // Id that slot 0 takes at this edge.
    always_comb begin
        case (i_ctl.op)
            OP_INSERT: o_head_next_id = w_gt[0] ? i_ctl.id : w_id[0];
            OP_POP:    o_head_next_id = w_id[1];
            default:   o_head_next_id = w_id[0];
        endcase
    end

endmodule

>>> design/time_ordered_event_chain.sv
// Top level of the time-ordered event chain: handshake, command sequencer, config port.
//
// Sorted queue of particle ids keyed by next event time (current_time + time_step,
// saturating at all ones), earliest at the head. Input channel carries one command
// item (clear, load, reschedule head); output channel returns one result item per
// command: head id, head valid, queue length and a drop flag.
// Storage is a row of MAX_ENTRIES cells; every cell compares its time against the
// broadcast key in parallel and shifts toward the tail (insert) or toward the head
// (pop) all at once, so no item ever walks the queue.
// After accept the command is latched and run in ST_EXEC, which writes the result
// register for every command but a kept reschedule; a kept reschedule pops in ST_EXEC,
// then reinserts and writes the result in ST_REINS. No new item is taken until idle;
// the chain takes one shift operation per cycle and a kept reschedule needs two.
// The next item is accepted once the result register is empty or is being taken,
// so a stalled receiver holds the result and the block simply waits in idle.
// Reset (i_rst_n low, synchronous) empties the queue, clears time_limit and drops
// any pending result; cell contents are not cleared, the entry count guards them.
// Config: time_limit at paddr 0, 64-bit data; write only while idle.
module time_ordered_event_chain
    import toec_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // command items
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_cmd                  i_command,
    input  t_id                   i_particle_id,
    input  t_time                 i_current_time,
    input  t_time                 i_time_step,
    input  logic                  i_has_neighbors,
    // result items
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_id                   o_head_id,
    output logic                  o_head_valid,
    output t_cnt                  o_queue_length,
    output logic                  o_was_dropped,
    // config port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [PADDR_BITS-1:0] paddr,
    input  logic [PDATA_BITS-1:0] pwdata,
    output logic [PDATA_BITS-1:0] prdata,
    output logic                  pready
);

    localparam t_cnt FULL_COUNT = t_cnt'(MAX_ENTRIES);

    t_state r_state, n_state;
    t_cnt   r_count, n_count;
    t_time  r_limit;

    // latched command
    t_cmd   r_cmd;
    t_id    r_pid;
    t_time  r_key;
    logic   r_keep;
    t_id    r_hid, n_hid;

    // result register
    logic   r_out_valid, n_out_valid;
    t_id    r_head_id,   n_head_id;
    t_cnt   r_len,       n_len;
    logic   r_drop,      n_drop;

    logic        w_accept;
    logic [TIME_BITS:0] w_sum;
    t_time       w_next_time;
    logic        w_out_free;
    logic        w_result;
    t_id         w_result_src;
    t_chain_ctl  w_ctl;
    t_id         w_head_id, w_head_next_id;

    // ---- config port ----
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= '0;
        end else if (psel && penable && pwrite && paddr[REG_SEL_BIT] == REG_TIME_LIMIT) begin
            r_limit <= pwdata[TIME_BITS-1:0];
        end
    end

    assign prdata = (paddr[REG_SEL_BIT] == REG_TIME_LIMIT) ? PDATA_BITS'(r_limit) : '0;

    // ---- input side ----
    assign w_out_free = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == ST_IDLE) && w_out_free;
    assign w_accept   = i_in_valid && o_in_ready;

    // Saturating next-event time; carry out means overflow.
    assign w_sum       = {1'b0, i_current_time} + {1'b0, i_time_step};
    assign w_next_time = w_sum[TIME_BITS] ? '1 : w_sum[TIME_BITS-1:0];

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd  <= i_command;
            r_pid  <= i_particle_id;
            r_key  <= w_next_time;
            r_keep <= i_has_neighbors && (w_next_time <= r_limit);
        end
        r_hid <= n_hid;
    end

    // ---- sequencer ----
    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_hid        = r_hid;
        w_ctl.op       = OP_HOLD;
        w_ctl.after_eq = 1'b1;
        w_ctl.key      = r_key;
        w_ctl.id       = r_pid;
        w_result     = 1'b0;
        w_result_src = w_head_id;
        n_len        = r_count;
        n_drop       = 1'b0;

        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                n_state  = ST_IDLE;
                w_result = 1'b1;
                case (r_cmd)
                    CMD_CLEAR: begin
                        n_count = '0;
                        n_len   = '0;
                    end
                    CMD_LOAD: begin
                        if (!r_keep || r_count == FULL_COUNT) begin
                            n_drop = 1'b1;
                        end else begin
                            w_ctl.op     = OP_INSERT;
                            n_count      = r_count + 1'b1;
                            n_len        = n_count;
                            w_result_src = w_head_next_id;
                        end
                    end
                    CMD_RESCHED: begin
                        if (r_count != '0) begin
                            // Pop the head; a kept head goes back in next cycle.
                            w_ctl.op = OP_POP;
                            n_hid    = w_head_id;
                            n_count  = r_count - 1'b1;
                            if (r_keep) begin
                                n_state  = ST_REINS;
                                w_result = 1'b0;
                            end else begin
                                n_drop       = 1'b1;
                                n_len        = n_count;
                                w_result_src = w_head_next_id;
                            end
                        end
                    end
                    default: begin
                    end
                endcase
            end
            ST_REINS: begin
                // Rescheduled entry goes before equal times.
                w_ctl.op       = OP_INSERT;
                w_ctl.after_eq = 1'b0;
                w_ctl.id       = r_hid;
                n_count        = r_count + 1'b1;
                n_len          = n_count;
                w_result_src   = w_head_next_id;
                w_result       = 1'b1;
                n_state        = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    // ---- result register ----
    assign n_head_id   = (n_len != '0) ? w_result_src : '0;
    assign n_out_valid = w_result || (r_out_valid && !i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_result) begin
            r_head_id <= n_head_id;
            r_len     <= n_len;
            r_drop    <= n_drop;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_head_id      = r_head_id;
    assign o_head_valid   = (r_len != '0);
    assign o_queue_length = r_len;
    assign o_was_dropped  = r_drop;

    // ---- storage ----
    toec_chain u_chain (
        .i_clk          (i_clk),
        .i_ctl          (w_ctl),
        .i_count        (r_count),
        .o_head_id      (w_head_id),
        .o_head_next_id (w_head_next_id)
    );

endmodule

>>> design/toec_checker.sv
// Port-level checks for the time-ordered event chain, bound to the top level.
module toec_checker
    import toec_pkg::*;
(
    input logic  i_clk,
    input logic  i_rst_n,
    input logic  i_in_valid,
    input logic  o_in_ready,
    input t_cmd  i_command,
    input logic  o_out_valid,
    input logic  i_out_ready,
    input t_id   o_head_id,
    input logic  o_head_valid,
    input t_cnt  o_queue_length,
    input logic  o_was_dropped
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_queue_length)
            && $stable(o_head_id) && $stable(o_was_dropped))
        else $error("result changed while stalled");

    a_head_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_head_valid == (o_queue_length != '0))
            && (o_head_valid || o_head_id == '0))
        else $error("head fields disagree with queue length");

    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_queue_length <= CNT_BITS'(MAX_ENTRIES))
        else $error("queue length beyond capacity");

    a_clear_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_command == CMD_CLEAR |=> ##1
            o_out_valid && o_queue_length == '0 && !o_was_dropped)
        else $error("clear did not empty the queue");

endmodule

bind time_ordered_event_chain toec_checker u_toec_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_ready     (o_in_ready),
    .i_command      (i_command),
    .o_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .o_head_id      (o_head_id),
    .o_head_valid   (o_head_valid),
    .o_queue_length (o_queue_length),
    .o_was_dropped  (o_was_dropped)
);

>>> verif/time_ordered_event_chain_tb.sv
// Self-checking testbench for the time-ordered event chain: directed table, then random phases.
module time_ordered_event_chain_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import toec_pkg::*;

    // Command code 3 has no meaning; the block must leave the queue alone.
    localparam t_cmd CMD_UNKNOWN = 2'd3;
    localparam logic [PADDR_BITS-1:0] ADDR_TIME_LIMIT =
        PADDR_BITS'({REG_TIME_LIMIT, {REG_SEL_BIT{1'b0}}});

    localparam t_time T_MAX  = {TIME_BITS{1'b1}};
    localparam t_time T_AAAA = {(TIME_BITS/2){2'b10}};
    localparam t_time T_5555 = {(TIME_BITS/2){2'b01}};
    localparam t_time T_HALF = {1'b0, {(TIME_BITS-1){1'b1}}};

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 8;
    localparam int FILL_ITEMS     = 1150;
    localparam int MIXED_ITEMS    = 260;
    localparam int PLAN_ROWS      = 23;

    typedef struct packed {
        t_cmd  cmd;
        t_id   pid;
        t_time cur;
        t_time step;
        logic  nb;
    } t_chain_event;

    typedef struct packed {
        t_id  head_id;
        logic head_valid;
        t_cnt queue_length;
        logic was_dropped;
    } t_chain_result;

    typedef struct packed {
        logic          set_lim;
        t_time         lim;
        t_chain_event  ev;
        logic          typed;     // want holds a hand-written expectation
        t_chain_result want;
    } t_plan_row;

    // Directed rows: reset state, saturation, keep test at the limit, tie order, drops.
    localparam t_plan_row DIRECTED_PLAN [PLAN_ROWS] = '{
        // empty queue right after reset, time_limit still at its reset value of zero
        '{1'b0, '0, '{CMD_RESCHED, 10'd0, '0, '0, 1'b1},
          1'b1, '{10'd0, 1'b0, 11'd0, 1'b0}},
        '{1'b0, '0, '{CMD_LOAD, 10'd5, '0, '0, 1'b1},
          1'b1, '{10'd5, 1'b1, 11'd1, 1'b0}},
        '{1'b0, '0, '{CMD_LOAD, 10'd1023, '0, 48'd1, 1'b1},
          1'b1, '{10'd5, 1'b1, 11'd1, 1'b1}},
        '{1'b0, '0, '{CMD_UNKNOWN, 10'd7, T_MAX, T_MAX, 1'b1},
          1'b1, '{10'd5, 1'b1, 11'd1, 1'b0}},
        '{1'b0, '0, '{CMD_LOAD, 10'd9, '0, '0, 1'b0},
          1'b1, '{10'd5, 1'b1, 11'd1, 1'b1}},
        '{1'b0, '0, '{CMD_CLEAR, 10'd0, '0, '0, 1'b0},
          1'b1, '{10'd0, 1'b0, 11'd0, 1'b0}},
        // sum saturates at all ones, still kept under the widest limit
        '{1'b1, T_MAX, '{CMD_LOAD, 10'd1023, T_MAX, T_MAX, 1'b1},
          1'b1, '{10'd1023, 1'b1, 11'd1, 1'b0}},
        '{1'b0, '0, '{CMD_LOAD, 10'h155, T_AAAA, T_5555, 1'b1},
          1'b1, '{10'd1023, 1'b1, 11'd2, 1'b0}},
        '{1'b0, '0, '{CMD_LOAD, 10'h2AA, T_MAX, 48'd1, 1'b1},
          1'b1, '{10'd1023, 1'b1, 11'd3, 1'b0}},
        // two loads at t=100 keep load order
        '{1'b0, '0, '{CMD_LOAD, 10'd10, 48'd100, '0, 1'b1},
          1'b1, '{10'd10, 1'b1, 11'd4, 1'b0}},
        '{1'b0, '0, '{CMD_LOAD, 10'd11, 48'd60, 48'd40, 1'b1},
          1'b1, '{10'd10, 1'b1, 11'd5, 1'b0}},
        // rescheduled head lands in front of the equal time
        '{1'b0, '0, '{CMD_RESCHED, 10'd0, 48'd50, 48'd50, 1'b1},
          1'b1, '{10'd10, 1'b1, 11'd5, 1'b0}},
        '{1'b0, '0, '{CMD_RESCHED, 10'd0, 48'd100, 48'd1, 1'b1},
          1'b1, '{10'd11, 1'b1, 11'd5, 1'b0}},
        // no neighbors: head removed
        '{1'b0, '0, '{CMD_RESCHED, 10'd0, '0, '0, 1'b0},
          1'b1, '{10'd10, 1'b1, 11'd4, 1'b1}},
        // limit 200: a time past it is dropped, exactly at the limit is kept
        '{1'b1, 48'd200, '{CMD_RESCHED, 10'd0, 48'd150, 48'd100, 1'b1},
          1'b1, '{10'd1023, 1'b1, 11'd3, 1'b1}},
        '{1'b0, '0, '{CMD_RESCHED, 10'd0, 48'd199, 48'd1, 1'b1},
          1'b1, '{10'd1023, 1'b1, 11'd3, 1'b0}},
        '{1'b0, '0, '{CMD_LOAD, 10'd3, 48'd199, 48'd1, 1'b1},
          1'b1, '{10'd1023, 1'b1, 11'd4, 1'b0}},
        '{1'b0, '0, '{CMD_LOAD, 10'd4, T_MAX, T_MAX, 1'b0},
          1'b1, '{10'd1023, 1'b1, 11'd4, 1'b1}},
        '{1'b1, T_5555, '{CMD_LOAD, 10'h200, T_5555, '0, 1'b1}, 1'b0, '0},
        '{1'b0, '0, '{CMD_RESCHED, 10'd0, T_5555, 48'd1, 1'b1}, 1'b0, '0},
        '{1'b0, '0, '{CMD_RESCHED, 10'd0, T_AAAA, '0, 1'b1}, 1'b0, '0},
        '{1'b0, '0, '{CMD_CLEAR, 10'd0, '0, '0, 1'b1},
          1'b1, '{10'd0, 1'b0, 11'd0, 1'b0}},
        '{1'b0, '0, '{CMD_RESCHED, 10'd0, '0, '0, 1'b1},
          1'b1, '{10'd0, 1'b0, 11'd0, 1'b0}}
    };

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_ready;
    t_cmd                  i_command;
    t_id                   i_particle_id;
    t_time                 i_current_time;
    t_time                 i_time_step;
    logic                  i_has_neighbors;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    t_id                   o_head_id;
    logic                  o_head_valid;
    t_cnt                  o_queue_length;
    logic                  o_was_dropped;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [PADDR_BITS-1:0] paddr;
    logic [PDATA_BITS-1:0] pwdata;
    logic [PDATA_BITS-1:0] prdata;
    logic                  pready;

    time_ordered_event_chain dut (.*);

    // Shadow of the queue, kept sorted with the head at index 0.
    t_time         sched_time [MAX_ENTRIES];
    t_id           sched_id   [MAX_ENTRIES];
    int unsigned   sched_len      = 0;
    t_time         limit_ticks    = '0;
    t_chain_result expected_results [$];

    int src_gap_pct     = 0;
    int sink_stall_pct  = 0;
    int mismatch_count  = 0;
    int items_sent      = 0;
    int results_seen    = 0;
    int limit_writes    = 0;
    int peak_len        = 0;
    int full_refusals   = 0;
    int idle_cycles     = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_time next_event_time(t_time cur, t_time step);
        logic [TIME_BITS:0] sum;
        sum = {1'b0, cur} + {1'b0, step};
        return sum[TIME_BITS] ? T_MAX : sum[TIME_BITS-1:0];
    endfunction

    // Loads go behind equal times, reschedules in front of them.
    function automatic void sched_insert(t_time key, t_id id, logic after_equal);
        int unsigned pos;
        pos = 0;
        while (pos < sched_len &&
               (after_equal ? sched_time[pos] <= key : sched_time[pos] < key))
            pos++;
        for (int unsigned k = sched_len; k > pos; k--) begin
            sched_time[k] = sched_time[k-1];
            sched_id[k]   = sched_id[k-1];
        end
        sched_time[pos] = key;
        sched_id[pos]   = id;
        sched_len++;
    endfunction

    function automatic t_chain_result apply_event(t_chain_event ev);
        t_time         key;
        logic          keep;
        t_id           popped;
        t_chain_result r;
        key  = next_event_time(ev.cur, ev.step);
        keep = ev.nb && (key <= limit_ticks);
        r    = '0;
        case (ev.cmd)
            CMD_CLEAR: begin
                sched_len = 0;
            end
            CMD_LOAD: begin
                if (!keep || sched_len >= MAX_ENTRIES) begin
                    r.was_dropped = 1'b1;
                    if (keep)
                        full_refusals++;
                end else begin
                    sched_insert(key, ev.pid, 1'b1);
                end
            end
            CMD_RESCHED: begin
                if (sched_len > 0) begin
                    popped = sched_id[0];
                    for (int unsigned k = 1; k < sched_len; k++) begin
                        sched_time[k-1] = sched_time[k];
                        sched_id[k-1]   = sched_id[k];
                    end
                    sched_len--;
                    if (keep)
                        sched_insert(key, popped, 1'b0);
                    else
                        r.was_dropped = 1'b1;
                end
            end
            default: ;
        endcase
        r.head_valid   = (sched_len > 0);
        r.head_id      = r.head_valid ? sched_id[0] : '0;
        r.queue_length = t_cnt'(sched_len);
        if (sched_len > peak_len)
            peak_len = sched_len;
        return r;
    endfunction

    function automatic t_time rand_ticks();
        return t_time'({$urandom(), $urandom()});
    endfunction

    function automatic t_time extreme_ticks();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return t_time'(1);
            2: return T_AAAA;
            3: return T_5555;
            4: return {1'b1, {(TIME_BITS-1){1'b0}}};
            default: return T_MAX;
        endcase
    endfunction

    // filling: loads and reschedules that are always kept, to push the queue to full.
    function automatic t_chain_event random_event(logic filling);
        t_chain_event    ev;
        int unsigned     pick;
        longint unsigned total;
        longint unsigned delta;
        ev.pid = t_id'($urandom());
        ev.nb  = ($urandom_range(0, 9) != 0);
        pick   = $urandom_range(0, 99);
        if (filling) begin
            ev.cmd = (pick < 92) ? CMD_LOAD : CMD_RESCHED;
            ev.nb  = 1'b1;
        end else begin
            ev.cmd = (pick < 50) ? CMD_LOAD :
                     (pick < 95) ? CMD_RESCHED :
                     (pick < 97) ? CMD_CLEAR : CMD_UNKNOWN;
        end
        if (filling && $urandom_range(0, 1) != 0) begin
            ev.cur  = t_time'($urandom_range(0, 511));
            ev.step = t_time'($urandom_range(0, 511));
        end else begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: begin
                    // sum lands just below or just above the limit
                    total = 64'(limit_ticks);
                    delta = 64'($urandom_range(0, 64));
                    if ($urandom_range(0, 1) != 0)
                        total = (total + delta > 64'(T_MAX)) ? 64'(T_MAX) : total + delta;
                    else
                        total = (total >= delta) ? total - delta : 64'd0;
                    ev.cur  = t_time'(64'(rand_ticks()) % (total + 64'd1));
                    ev.step = t_time'(total - 64'(ev.cur));
                end
                5, 6: begin
                    // tiny times: lots of ties
                    ev.cur  = t_time'($urandom_range(0, 7));
                    ev.step = t_time'($urandom_range(0, 3));
                end
                7: begin
                    ev.cur  = rand_ticks();
                    ev.step = rand_ticks();
                end
                8: begin
                    ev.cur  = extreme_ticks();
                    ev.step = extreme_ticks();
                end
                default: begin
                    ev.cur  = rand_ticks();
                    ev.step = T_MAX - t_time'($urandom_range(0, 3));
                end
            endcase
        end
        return ev;
    endfunction

    task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
        mismatch_count++;
        $display("mismatch at %0t: %s got %0h, want %0h", $realtime, what, got, want);
    endtask

    // Holds the item until accepted; valid stays up when the next item follows at once.
    task automatic send_event(t_chain_event ev, logic typed, t_chain_result want);
        t_chain_result predicted;
        if ($urandom_range(0, 99) < src_gap_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_command       <= ev.cmd;
        i_particle_id   <= ev.pid;
        i_current_time  <= ev.cur;
        i_time_step     <= ev.step;
        i_has_neighbors <= ev.nb;
        do @(posedge i_clk); while (!o_in_ready);
        predicted = apply_event(ev);
        expected_results.insert(expected_results.size(), typed ? want : predicted);
        items_sent++;
    endtask

    task automatic wait_for_results();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (expected_results.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Write time_limit while idle, then read it back.
    task automatic write_time_limit(logic [PDATA_BITS-1:0] value);
        wait_for_results();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_TIME_LIMIT;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        limit_ticks = value[TIME_BITS-1:0];
        limit_writes++;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata[TIME_BITS-1:0] !== limit_ticks)
            report_mismatch("time_limit readback", 64'(prdata[TIME_BITS-1:0]),
                            64'(limit_ticks));
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // Receiver: ready drops at random per cycle.
    always @(posedge i_clk)
        i_out_ready <= ($urandom_range(0, 99) >= sink_stall_pct);

    always @(posedge i_clk) begin : result_check
        t_chain_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            results_seen++;
            if (expected_results.size() == 0) begin
                report_mismatch("result with nothing pending, queue_length",
                                64'(o_queue_length), 64'd0);
            end else begin
                want = expected_results.pop_front();
                if (o_head_id !== want.head_id)
                    report_mismatch("head_id", 64'(o_head_id), 64'(want.head_id));
                if (o_head_valid !== want.head_valid)
                    report_mismatch("head_valid", 64'(o_head_valid), 64'(want.head_valid));
                if (o_queue_length !== want.queue_length)
                    report_mismatch("queue_length", 64'(o_queue_length),
                                    64'(want.queue_length));
                if (o_was_dropped !== want.was_dropped)
                    report_mismatch("was_dropped", 64'(o_was_dropped),
                                    64'(want.was_dropped));
            end
        end
    end

    // Any handshake on any port resets the count; a stuck block runs it out.
    always @(posedge i_clk) begin : watchdog
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (psel && penable)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("time_ordered_event_chain regression: fail");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : stimulus
        i_rst_n         <= 1'b0;
        i_in_valid      <= 1'b0;
        i_command       <= CMD_CLEAR;
        i_particle_id   <= '0;
        i_current_time  <= '0;
        i_time_step     <= '0;
        i_has_neighbors <= 1'b0;
        psel            <= 1'b0;
        penable         <= 1'b0;
        pwrite          <= 1'b0;
        paddr           <= '0;
        pwdata          <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table, light idling on both sides.
        src_gap_pct    = 10;
        sink_stall_pct = 10;
        for (int r = 0; r < PLAN_ROWS; r++) begin
            if (DIRECTED_PLAN[r].set_lim)
                write_time_limit(PDATA_BITS'(DIRECTED_PLAN[r].lim));
            send_event(DIRECTED_PLAN[r].ev, DIRECTED_PLAN[r].typed, DIRECTED_PLAN[r].want);
        end

        // No idling: fill to capacity, later loads bounce off the full queue.
        write_time_limit(PDATA_BITS'(T_MAX));
        src_gap_pct    = 0;
        sink_stall_pct = 0;
        for (int n = 0; n < FILL_ITEMS; n++)
            send_event(random_event(1'b1), 1'b0, '0);

        // Sender pauses before 60 items of a hundred, random limit.
        write_time_limit(PDATA_BITS'(rand_ticks()));
        src_gap_pct    = 60;
        sink_stall_pct = 0;
        for (int n = 0; n < MIXED_ITEMS; n++)
            send_event(random_event(1'b0), 1'b0, '0);

        // Receiver stalling at a 60 percent chance, limit at half range.
        write_time_limit(PDATA_BITS'(T_HALF));
        src_gap_pct    = 0;
        sink_stall_pct = 60;
        for (int n = 0; n < MIXED_ITEMS; n++)
            send_event(random_event(1'b0), 1'b0, '0);

        // Both sides idle in 10, small limit: many drops and ties.
        write_time_limit(PDATA_BITS'(t_time'(600)));
        src_gap_pct    = 10;
        sink_stall_pct = 10;
        for (int n = 0; n < MIXED_ITEMS; n++)
            send_event(random_event(1'b0), 1'b0, '0);

        wait_for_results();

        $display("covered %0d items and %0d results over %0d limit settings",
                 items_sent, results_seen, limit_writes);
        $display("deepest queue %0d entries, %0d kept loads turned away by a full queue",
                 peak_len, full_refusals);
        if (mismatch_count == 0 && results_seen == items_sent &&
            expected_results.size() == 0)
            $display("time_ordered_event_chain regression: pass");
        else
            $display("time_ordered_event_chain regression: fail");
        $finish;
    end

endmodule
